@@ sv/vcde_pkg.sv @@
package vcde_pkg;

    typedef enum logic [2:0] {
        ACT_WHOLE  = 3'd0,
        ACT_LAYER  = 3'd1,
        ACT_VOXEL  = 3'd2,
        ACT_FILL   = 3'd3,
        ACT_HOLLOW = 3'd4,
        ACT_EDGES  = 3'd5,
        ACT_LINE   = 3'd6,
        ACT_READ   = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        MODE_SET    = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_INVERT = 2'd2,
        MODE_BAD    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_RD,
        ST_WR,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        KIND_BYTES,
        KIND_BOX,
        KIND_LINE,
        KIND_READ
    } t_kind;

    localparam logic [7:0] MASK_ALL = 8'hFF;
    localparam logic [3:0] LAST_HOLLOW = 4'd5;
    localparam logic [3:0] LAST_EDGES  = 4'd11;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] mode;
        logic [3:0] x_a;
        logic [3:0] y_a;
        logic [3:0] z_a;
        logic [3:0] x_b;
        logic [3:0] y_b;
        logic [3:0] z_b;
        logic [3:0] byte_index;
    } t_in_item;

    typedef struct packed {
        logic       status;
        logic [7:0] read_data;
    } t_out_item;

    typedef struct packed {
        t_in_item item;
        logic     err;
    } t_cmd;

    typedef logic signed [5:0] t_coord;

    typedef struct packed {
        t_coord x1;
        t_coord y1;
        t_coord z1;
        t_coord x2;
        t_coord y2;
        t_coord z2;
    } t_box;

    function automatic logic [7:0] apply_byte(logic [7:0] d, logic [7:0] m, logic [1:0] mode);
        logic [7:0] r;
        case (mode)
            MODE_SET:   r = d | m;
            MODE_CLEAR: r = d & ~m;
            default:    r = d ^ m;
        endcase
        return r;
    endfunction

    function automatic t_coord ext(logic [3:0] v);
        return $signed({2'b00, v});
    endfunction

    function automatic t_box mk(t_coord x1, t_coord y1, t_coord z1,
                                t_coord x2, t_coord y2, t_coord z2);
        t_box b;
        b.x1 = x1; b.y1 = y1; b.z1 = z1;
        b.x2 = x2; b.y2 = y2; b.z2 = z2;
        return b;
    endfunction

    // k-th box of a command; hollow faces and cube edges are all boxes
    function automatic t_box sub_box(t_in_item c, logic [3:0] k);
        t_coord xa, ya, za, xb, yb, zb, ya1, yb1, za1, zb1, y;
        t_box   b;
        xa = ext(c.x_a); ya = ext(c.y_a); za = ext(c.z_a);
        xb = ext(c.x_b); yb = ext(c.y_b); zb = ext(c.z_b);
        ya1 = ya + 6'sd1; yb1 = yb - 6'sd1;
        za1 = za + 6'sd1; zb1 = zb - 6'sd1;
        y = k[2] ? yb : ya;
        b = mk(xa, ya, za, xb, yb, zb);
        if (c.action == ACT_VOXEL) begin
            b = mk(xa, ya, za, xa, ya, za);
        end else if (c.action == ACT_HOLLOW) begin
            case (k)
                4'd0:    b = mk(xa, ya, za, xb, ya, zb);
                4'd1:    b = mk(xa, yb, za, xb, yb, zb);
                4'd2:    b = mk(xa, ya1, za, xb, yb1, za);
                4'd3:    b = mk(xa, ya1, zb, xb, yb1, zb);
                4'd4:    b = mk(xb, ya1, za1, xb, yb1, zb1);
                default: b = mk(xa, ya1, za1, xa, yb1, zb1);
            endcase
        end else if (c.action == ACT_EDGES) begin
            case (k)
                4'd0, 4'd4: b = mk(xa, y, za, xa, y, zb);
                4'd1, 4'd5: b = mk(xa, y, za, xb, y, za);
                4'd2, 4'd6: b = mk(xa, y, zb, xb, y, zb);
                4'd3, 4'd7: b = mk(xb, y, za, xb, y, zb);
                4'd8:       b = mk(xa, ya, za, xa, yb, za);
                4'd9:       b = mk(xb, ya, za, xb, yb, za);
                4'd10:      b = mk(xa, ya, zb, xa, yb, zb);
                default:    b = mk(xb, ya, zb, xb, yb, zb);
            endcase
        end
        return b;
    endfunction

endpackage

@@ sv/voxel_cube_draw_engine_core.sv @@
// Channel   Direction  Handshake                     Payload
// command   in         i_in_valid / o_in_ready       i_in_item  (vcde_pkg::t_in_item)
// result    out        o_out_valid / i_out_ready     o_out_item (vcde_pkg::t_out_item)
//
// Each voxel or byte touched is a read-modify-write on the single frame buffer
// RAM: a read state (ST_RD) followed by a write state (ST_WR).
// Reset: a clearing sweep zeroes all CUBE_EDGE * LAYER_BYTES bytes (130 by
// default) of the buffer, one byte a cycle; o_in_ready stays low through it.
// Stalls: a two-item queue lets commands arrive while the engine works; a held
// result only stops the engine when the next result is ready to go.
module voxel_cube_draw_engine_core #(
    parameter int CUBE_EDGE   = 10,
    parameter int LAYER_BYTES = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vcde_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vcde_pkg::t_out_item o_out_item
);

    // one row per layer, y-major
    localparam int DEPTH = CUBE_EDGE * LAYER_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic           clearing;
    logic           q_valid, q_pop;
    vcde_pkg::t_cmd q_cmd;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]     ram_wdata, ram_rdata;

    // front: range / mode checks, then the command queue
    vcde_front #(
        .CUBE_EDGE   (CUBE_EDGE),
        .LAYER_BYTES (LAYER_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clearing (clearing),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    // back: shape walker (bytes, boxes, Bresenham line) with RMW on the buffer
    vcde_back #(
        .CUBE_EDGE   (CUBE_EDGE),
        .LAYER_BYTES (LAYER_BYTES),
        .AW          (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // frame buffer
    vcde_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_fb (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

@@ sv/vcde_ram.sv @@
module vcde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 130
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/vcde_front.sv @@
module vcde_front #(
    parameter int CUBE_EDGE   = 10,
    parameter int LAYER_BYTES = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clearing,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  vcde_pkg::t_in_item i_in_item,
    output logic              o_q_valid,
    output vcde_pkg::t_cmd    o_q_cmd,
    input  logic              i_q_pop
);

    vcde_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           err, mbad, push;

    function automatic logic bad(logic [3:0] v);
        return int'(v) > CUBE_EDGE - 1;
    endfunction

    always_comb begin
        mbad = i_in_item.mode == vcde_pkg::MODE_BAD;
        unique case (vcde_pkg::t_action'(i_in_item.action))
            vcde_pkg::ACT_WHOLE: err = mbad;
            vcde_pkg::ACT_LAYER: err = mbad | bad(i_in_item.y_a);
            vcde_pkg::ACT_VOXEL: err = mbad | bad(i_in_item.x_a) | bad(i_in_item.y_a)
                                       | bad(i_in_item.z_a);
            vcde_pkg::ACT_FILL, vcde_pkg::ACT_HOLLOW, vcde_pkg::ACT_EDGES:
                err = mbad | bad(i_in_item.x_a) | bad(i_in_item.y_a) | bad(i_in_item.z_a)
                    | bad(i_in_item.x_b) | bad(i_in_item.y_b) | bad(i_in_item.z_b)
                    | (i_in_item.x_a > i_in_item.x_b) | (i_in_item.y_a > i_in_item.y_b)
                    | (i_in_item.z_a > i_in_item.z_b);
            vcde_pkg::ACT_LINE:  err = mbad;
            default:             err = bad(i_in_item.y_a)
                                       | (int'(i_in_item.byte_index) >= LAYER_BYTES);
        endcase
    end

    assign o_in_ready = (r_cnt != 2'd2) && !i_clearing;
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = r_cnt != 2'd0;
    assign o_q_cmd    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{item: i_in_item, err: err};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

@@ sv/vcde_back.sv @@
module vcde_back #(
    parameter int CUBE_EDGE   = 10,
    parameter int LAYER_BYTES = 13,
    parameter int AW          = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  vcde_pkg::t_cmd     i_q_cmd,
    output logic               o_q_pop,
    output logic               o_clearing,
    output logic               o_ram_we,
    output logic [AW-1:0]      o_ram_waddr,
    output logic [7:0]         o_ram_wdata,
    output logic [AW-1:0]      o_ram_raddr,
    input  logic [7:0]         i_ram_rdata,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vcde_pkg::t_out_item o_out_item
);

    localparam int DEPTH = CUBE_EDGE * LAYER_BYTES;

    vcde_pkg::t_state r_state, n_state;
    vcde_pkg::t_kind  r_kind, n_kind;
    vcde_pkg::t_cmd   r_cmd, n_cmd;
    vcde_pkg::t_box   r_box, n_box;
    vcde_pkg::t_coord r_x, r_y, r_z, n_x, n_y, n_z;
    vcde_pkg::t_coord r_p [3];
    vcde_pkg::t_coord n_p [3];
    logic [2:0]       r_neg, n_neg;
    logic [1:0]       r_prim, r_sec1, r_sec2, n_prim, n_sec1, n_sec2;
    logic signed [7:0] r_e1, r_e2, n_e1, n_e2;
    logic [4:0]       r_dp2, r_d12, r_d22, n_dp2, n_d12, n_d22;
    logic [3:0]       r_left, n_left, r_k, n_k;
    logic [AW-1:0]    r_baddr, n_baddr, r_bend, n_bend, r_waddr, n_waddr;
    logic [7:0]       r_mask, n_mask, r_rdata, n_rdata;
    logic             r_skip, n_skip, r_err, n_err;
    logic             r_ovalid, n_ovalid;
    vcde_pkg::t_out_item r_oitem, n_oitem;

    // voxel address path
    logic [3:0] vx, vy, vz;
    logic [AW-1:0] v_addr;
    logic [7:0]    v_mask;
    logic          v_skip;

    function automatic logic in_rng(vcde_pkg::t_coord v);
        return (v >= 6'sd0) && (int'(v) <= CUBE_EDGE - 1);
    endfunction

    always_comb begin
        int idx;
        int byt;
        if (r_kind == vcde_pkg::KIND_LINE) begin
            vx = r_p[0][3:0]; vy = r_p[1][3:0]; vz = r_p[2][3:0];
        end else begin
            vx = r_x[3:0]; vy = r_y[3:0]; vz = r_z[3:0];
        end
        idx    = CUBE_EDGE * int'(vz) + int'(vx);
        byt    = idx / 8;
        v_skip = byt >= LAYER_BYTES;
        v_addr = AW'(int'(vy) * LAYER_BYTES + (v_skip ? 0 : byt));
        v_mask = 8'h01 << 3'(idx % 8);
    end

    // box walk and sub-box sequencing
    vcde_pkg::t_box sb;
    logic           sb_ok, box_end;
    logic [3:0]     k_last;

    always_comb begin
        sb    = vcde_pkg::sub_box(r_cmd.item, r_k);
        sb_ok = in_rng(sb.x1) && in_rng(sb.y1) && in_rng(sb.z1)
             && in_rng(sb.x2) && in_rng(sb.y2) && in_rng(sb.z2)
             && (sb.x1 <= sb.x2) && (sb.y1 <= sb.y2) && (sb.z1 <= sb.z2);
        box_end = (r_x == r_box.x2) && (r_y == r_box.y2) && (r_z == r_box.z2);
        case (r_cmd.item.action)
            vcde_pkg::ACT_HOLLOW: k_last = vcde_pkg::LAST_HOLLOW;
            vcde_pkg::ACT_EDGES:  k_last = vcde_pkg::LAST_EDGES;
            default:              k_last = 4'd0;
        endcase
    end

    // line setup from the queue head
    logic [3:0]       ld [3];
    logic             lneg [3];
    logic [1:0]       lp, ls1, ls2;
    vcde_pkg::t_coord la [3];
    vcde_pkg::t_coord lb [3];

    always_comb begin
        vcde_pkg::t_coord dd;
        la[0] = vcde_pkg::ext(i_q_cmd.item.x_a);
        la[1] = vcde_pkg::ext(i_q_cmd.item.y_a);
        la[2] = vcde_pkg::ext(i_q_cmd.item.z_a);
        lb[0] = vcde_pkg::ext(i_q_cmd.item.x_b);
        lb[1] = vcde_pkg::ext(i_q_cmd.item.y_b);
        lb[2] = vcde_pkg::ext(i_q_cmd.item.z_b);
        for (int j = 0; j < 3; j++) begin
            dd      = lb[j] - la[j];
            lneg[j] = dd < 6'sd0;
            ld[j]   = lneg[j] ? 4'(-dd) : 4'(dd);
        end
        if (ld[0] >= ld[1] && ld[0] >= ld[2]) begin
            lp = 2'd0; ls1 = 2'd1; ls2 = 2'd2;
        end else if (ld[1] >= ld[0] && ld[1] >= ld[2]) begin
            lp = 2'd1; ls1 = 2'd0; ls2 = 2'd2;
        end else begin
            lp = 2'd2; ls1 = 2'd1; ls2 = 2'd0;
        end
    end

    always_comb begin
        logic mv;
        n_state = r_state; n_kind = r_kind; n_cmd = r_cmd; n_box = r_box;
        n_x = r_x; n_y = r_y; n_z = r_z; n_p = r_p; n_neg = r_neg;
        n_prim = r_prim; n_sec1 = r_sec1; n_sec2 = r_sec2;
        n_e1 = r_e1; n_e2 = r_e2; n_dp2 = r_dp2; n_d12 = r_d12; n_d22 = r_d22;
        n_left = r_left; n_k = r_k; n_baddr = r_baddr; n_bend = r_bend;
        n_waddr = r_waddr; n_mask = r_mask; n_skip = r_skip;
        n_rdata = r_rdata; n_err = r_err;
        n_ovalid = r_ovalid && !i_out_ready; n_oitem = r_oitem;
        o_q_pop = 1'b0;
        o_ram_we = 1'b0;
        o_ram_waddr = r_waddr;
        o_ram_wdata = vcde_pkg::apply_byte(i_ram_rdata, r_mask, r_cmd.item.mode);
        o_ram_raddr = r_baddr;
        unique case (r_state)
            vcde_pkg::ST_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_baddr;
                o_ram_wdata = 8'h00;
                n_baddr     = r_baddr + AW'(1);
                if (int'(r_baddr) == DEPTH - 1) begin
                    n_state = vcde_pkg::ST_IDLE;
                end
            end
            vcde_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_err   = i_q_cmd.err;
                    n_rdata = 8'h00;
                    n_k     = 4'd0;
                    n_baddr = AW'(int'(i_q_cmd.item.y_a) * LAYER_BYTES);
                    n_bend  = AW'(int'(i_q_cmd.item.y_a) * LAYER_BYTES + LAYER_BYTES - 1);
                    n_state = vcde_pkg::ST_RD;
                    if (i_q_cmd.err) begin
                        n_state = vcde_pkg::ST_DONE;
                    end else begin
                        unique case (vcde_pkg::t_action'(i_q_cmd.item.action))
                            vcde_pkg::ACT_WHOLE: begin
                                n_kind  = vcde_pkg::KIND_BYTES;
                                n_baddr = '0;
                                n_bend  = AW'(DEPTH - 1);
                            end
                            vcde_pkg::ACT_LAYER: n_kind = vcde_pkg::KIND_BYTES;
                            vcde_pkg::ACT_READ: begin
                                n_kind  = vcde_pkg::KIND_READ;
                                n_baddr = AW'(int'(i_q_cmd.item.y_a) * LAYER_BYTES
                                              + int'(i_q_cmd.item.byte_index));
                            end
                            vcde_pkg::ACT_LINE: begin
                                n_kind = vcde_pkg::KIND_LINE;
                                n_p    = la;
                                n_neg  = {lneg[2], lneg[1], lneg[0]};
                                n_prim = lp; n_sec1 = ls1; n_sec2 = ls2;
                                n_dp2  = {ld[lp], 1'b0};
                                n_d12  = {ld[ls1], 1'b0};
                                n_d22  = {ld[ls2], 1'b0};
                                n_e1   = $signed({3'b000, ld[ls1], 1'b0})
                                       - $signed({4'b0000, ld[lp]});
                                n_e2   = $signed({3'b000, ld[ls2], 1'b0})
                                       - $signed({4'b0000, ld[lp]});
                                n_left = ld[lp];
                            end
                            default: begin
                                n_kind  = vcde_pkg::KIND_BOX;
                                n_state = vcde_pkg::ST_SETUP;
                            end
                        endcase
                    end
                end
            end
            vcde_pkg::ST_SETUP: begin
                if (sb_ok) begin
                    n_box = sb; n_x = sb.x1; n_y = sb.y1; n_z = sb.z1;
                    n_state = vcde_pkg::ST_RD;
                end else if (r_k == k_last) begin
                    n_state = vcde_pkg::ST_DONE;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            vcde_pkg::ST_RD: begin
                n_state = vcde_pkg::ST_WR;
                n_waddr = r_baddr;
                n_mask  = vcde_pkg::MASK_ALL;
                n_skip  = 1'b0;
                if (r_kind == vcde_pkg::KIND_BOX || r_kind == vcde_pkg::KIND_LINE) begin
                    o_ram_raddr = v_addr;
                    n_waddr = v_addr;
                    n_mask  = v_mask;
                    n_skip  = v_skip;
                end
                if (r_kind == vcde_pkg::KIND_LINE
                    && !(in_rng(r_p[0]) && in_rng(r_p[1]) && in_rng(r_p[2]))) begin
                    n_err   = 1'b1;
                    n_state = vcde_pkg::ST_DONE;
                end
            end
            vcde_pkg::ST_WR: begin
                o_ram_we = !r_skip && r_kind != vcde_pkg::KIND_READ;
                n_state  = vcde_pkg::ST_RD;
                unique case (r_kind)
                    vcde_pkg::KIND_READ: begin
                        n_rdata = i_ram_rdata;
                        n_state = vcde_pkg::ST_DONE;
                    end
                    vcde_pkg::KIND_BYTES: begin
                        n_baddr = r_baddr + AW'(1);
                        if (r_baddr == r_bend) begin
                            n_state = vcde_pkg::ST_DONE;
                        end
                    end
                    vcde_pkg::KIND_BOX: begin
                        if (r_y != r_box.y2) begin
                            n_y = r_y + 6'sd1;
                        end else begin
                            n_y = r_box.y1;
                            if (r_z != r_box.z2) begin
                                n_z = r_z + 6'sd1;
                            end else begin
                                n_z = r_box.z1;
                                n_x = r_x + 6'sd1;
                            end
                        end
                        if (box_end) begin
                            n_state = (r_k == k_last) ? vcde_pkg::ST_DONE
                                                      : vcde_pkg::ST_SETUP;
                            n_k = r_k + 4'd1;
                        end
                    end
                    default: begin
                        if (r_left == 4'd0) begin
                            n_state = vcde_pkg::ST_DONE;
                        end else begin
                            n_left = r_left - 4'd1;
                            for (int j = 0; j < 3; j++) begin
                                mv = (2'(j) == r_prim)
                                   || (2'(j) == r_sec1 && r_e1 > 8'sd0)
                                   || (2'(j) == r_sec2 && r_e2 > 8'sd0);
                                if (mv) begin
                                    n_p[j] = r_neg[j] ? r_p[j] - 6'sd1 : r_p[j] + 6'sd1;
                                end
                            end
                            n_e1 = r_e1 + $signed({3'b000, r_d12})
                                 - ((r_e1 > 8'sd0) ? $signed({3'b000, r_dp2}) : 8'sd0);
                            n_e2 = r_e2 + $signed({3'b000, r_d22})
                                 - ((r_e2 > 8'sd0) ? $signed({3'b000, r_dp2}) : 8'sd0);
                        end
                    end
                endcase
            end
            default: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_oitem.status    = r_err;
                    n_oitem.read_data = r_err ? 8'h00 : r_rdata;
                    n_state  = vcde_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vcde_pkg::ST_CLEAR;
            r_baddr  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_baddr  <= n_baddr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_cmd <= n_cmd; r_box <= n_box;
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_p <= n_p; r_neg <= n_neg;
        r_prim <= n_prim; r_sec1 <= n_sec1; r_sec2 <= n_sec2;
        r_e1 <= n_e1; r_e2 <= n_e2; r_dp2 <= n_dp2; r_d12 <= n_d12; r_d22 <= n_d22;
        r_left <= n_left; r_k <= n_k; r_bend <= n_bend; r_waddr <= n_waddr;
        r_mask <= n_mask; r_skip <= n_skip; r_rdata <= n_rdata; r_err <= n_err;
        r_oitem <= n_oitem;
    end

    assign o_clearing  = r_state == vcde_pkg::ST_CLEAR;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

endmodule

@@ bench/voxel_cube_draw_engine_core_tb.sv @@
`timescale 1ns / 1ps

module voxel_cube_draw_engine_core_tb;

    localparam int EDGE = 10;
    localparam int NBYTES = 13;
    localparam int IN_W = $bits(vcde_pkg::t_in_item);

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    vcde_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    vcde_pkg::t_out_item o_out_item;

    voxel_cube_draw_engine_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Shadow copy of the frame buffer, updated as each command is accepted.
    logic [7:0] shadow_fb [EDGE][NBYTES];

    vcde_pkg::t_in_item  cmd_queue[$];
    vcde_pkg::t_out_item result_queue[$];
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    function automatic logic in_cube(int v);
        return v >= 0 && v <= EDGE - 1;
    endfunction

    function automatic logic [7:0] merge_byte(logic [7:0] d, logic [7:0] m, logic [1:0] md);
        case (md)
            vcde_pkg::MODE_SET:   return d | m;
            vcde_pkg::MODE_CLEAR: return d & ~m;
            default:              return d ^ m;
        endcase
    endfunction

    function automatic void touch_voxel(int x, int y, int z, logic [1:0] md);
        int idx;
        idx = EDGE * z + x;
        if (idx / 8 < NBYTES) begin
            shadow_fb[y][idx / 8] = merge_byte(shadow_fb[y][idx / 8],
                                               8'(1 << (idx % 8)), md);
        end
    endfunction

    // single voxel with range/mode checks; returns 1 on error
    function automatic logic voxel_step(int x, int y, int z, logic [1:0] md);
        if (!in_cube(x) || !in_cube(y) || !in_cube(z) || md == vcde_pkg::MODE_BAD) begin
            return 1'b1;
        end
        touch_voxel(x, y, z, md);
        return 1'b0;
    endfunction

    // filled region; empty ranges simply do nothing
    function automatic void fill_region(int x1, int y1, int z1, int x2, int y2, int z2,
                                        logic [1:0] md);
        if (!in_cube(x1) || !in_cube(y1) || !in_cube(z1) ||
            !in_cube(x2) || !in_cube(y2) || !in_cube(z2)) begin
            return;
        end
        for (int x = x1; x <= x2; x++) begin
            for (int z = z1; z <= z2; z++) begin
                for (int y = y1; y <= y2; y++) begin
                    touch_voxel(x, y, z, md);
                end
            end
        end
    endfunction

    // 3D Bresenham; stops at the first voxel out of the cube
    function automatic logic trace_line(int x1, int y1, int z1, int x2, int y2, int z2,
                                        logic [1:0] md);
        int px, py, pz, e1, e2, sx, sy, sz, l, m, n;
        sx = (x2 < x1) ? -1 : 1;
        sy = (y2 < y1) ? -1 : 1;
        sz = (z2 < z1) ? -1 : 1;
        l = (x2 - x1) * sx;
        m = (y2 - y1) * sy;
        n = (z2 - z1) * sz;
        px = x1; py = y1; pz = z1;
        if (l >= m && l >= n) begin
            e1 = 2 * m - l; e2 = 2 * n - l;
            for (int i = 0; i < l; i++) begin
                if (voxel_step(px, py, pz, md)) return 1'b1;
                if (e1 > 0) begin py += sy; e1 -= 2 * l; end
                if (e2 > 0) begin pz += sz; e2 -= 2 * l; end
                e1 += 2 * m; e2 += 2 * n; px += sx;
            end
        end else if (m >= l && m >= n) begin
            e1 = 2 * l - m; e2 = 2 * n - m;
            for (int i = 0; i < m; i++) begin
                if (voxel_step(px, py, pz, md)) return 1'b1;
                if (e1 > 0) begin px += sx; e1 -= 2 * m; end
                if (e2 > 0) begin pz += sz; e2 -= 2 * m; end
                e1 += 2 * l; e2 += 2 * n; py += sy;
            end
        end else begin
            e1 = 2 * m - n; e2 = 2 * l - n;
            for (int i = 0; i < n; i++) begin
                if (voxel_step(px, py, pz, md)) return 1'b1;
                if (e1 > 0) begin py += sy; e1 -= 2 * n; end
                if (e2 > 0) begin px += sx; e2 -= 2 * n; end
                e1 += 2 * m; e2 += 2 * l; pz += sz;
            end
        end
        return voxel_step(px, py, pz, md);
    endfunction

    // Apply one command to the shadow buffer and return the expected result.
    function automatic vcde_pkg::t_out_item draw_and_predict(vcde_pkg::t_in_item c);
        vcde_pkg::t_out_item r;
        int         xa, ya, za, xb, yb, zb, y;
        logic       err, bad_box;
        logic [1:0] md;
        xa = c.x_a; ya = c.y_a; za = c.z_a;
        xb = c.x_b; yb = c.y_b; zb = c.z_b;
        md = c.mode;
        err = 1'b0;
        r.read_data = 8'h00;
        bad_box = !in_cube(xa) || !in_cube(ya) || !in_cube(za) ||
                  !in_cube(xb) || !in_cube(yb) || !in_cube(zb) ||
                  xa > xb || ya > yb || za > zb || md == vcde_pkg::MODE_BAD;
        case (vcde_pkg::t_action'(c.action))
            vcde_pkg::ACT_WHOLE: begin
                if (md == vcde_pkg::MODE_BAD) begin
                    err = 1'b1;
                end else begin
                    for (int yy = 0; yy < EDGE; yy++)
                        for (int b = 0; b < NBYTES; b++)
                            shadow_fb[yy][b] = merge_byte(shadow_fb[yy][b], 8'hFF, md);
                end
            end
            vcde_pkg::ACT_LAYER: begin
                if (!in_cube(ya) || md == vcde_pkg::MODE_BAD) begin
                    err = 1'b1;
                end else begin
                    for (int b = 0; b < NBYTES; b++)
                        shadow_fb[ya][b] = merge_byte(shadow_fb[ya][b], 8'hFF, md);
                end
            end
            vcde_pkg::ACT_VOXEL: err = voxel_step(xa, ya, za, md);
            vcde_pkg::ACT_FILL: begin
                err = bad_box;
                if (!err) fill_region(xa, ya, za, xb, yb, zb, md);
            end
            vcde_pkg::ACT_HOLLOW: begin
                err = bad_box;
                if (!err) begin
                    // top, bottom, front, back, right, left
                    fill_region(xa, ya, za, xb, ya, zb, md);
                    fill_region(xa, yb, za, xb, yb, zb, md);
                    fill_region(xa, ya + 1, za, xb, yb - 1, za, md);
                    fill_region(xa, ya + 1, zb, xb, yb - 1, zb, md);
                    fill_region(xb, ya + 1, za + 1, xb, yb - 1, zb - 1, md);
                    fill_region(xa, ya + 1, za + 1, xa, yb - 1, zb - 1, md);
                end
            end
            vcde_pkg::ACT_EDGES: begin
                err = bad_box;
                if (!err) begin
                    for (int k = 0; k < 2; k++) begin
                        y = k ? yb : ya;
                        void'(trace_line(xa, y, za, xa, y, zb, md));
                        void'(trace_line(xa, y, za, xb, y, za, md));
                        void'(trace_line(xa, y, zb, xb, y, zb, md));
                        void'(trace_line(xb, y, za, xb, y, zb, md));
                    end
                    void'(trace_line(xa, ya, za, xa, yb, za, md));
                    void'(trace_line(xb, ya, za, xb, yb, za, md));
                    void'(trace_line(xa, ya, zb, xa, yb, zb, md));
                    void'(trace_line(xb, ya, zb, xb, yb, zb, md));
                end
            end
            vcde_pkg::ACT_LINE: err = trace_line(xa, ya, za, xb, yb, zb, md);
            default: begin
                if (!in_cube(ya) || c.byte_index >= NBYTES) err = 1'b1;
                else r.read_data = shadow_fb[ya][c.byte_index];
            end
        endcase
        r.status = err;
        if (err) r.read_data = 8'h00;
        return r;
    endfunction

    // Driver: presents queued items, idles at random between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_item  <= cmd_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Predict on acceptance, in acceptance order.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            result_queue.push_back(draw_and_predict(i_in_item));
        end
    end

    // Monitor: random back-pressure and result checking.
    always @(posedge i_clk) begin
        vcde_pkg::t_out_item exp_r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (o_out_valid && i_out_ready) begin
                if (result_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item: status %0b data %02h",
                                 o_out_item.status, o_out_item.read_data);
                end else begin
                    exp_r = result_queue.pop_front();
                    if (o_out_item.status !== exp_r.status ||
                        o_out_item.read_data !== exp_r.read_data) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected status %0b data %02h, got %0b %02h",
                                     exp_r.status, exp_r.read_data,
                                     o_out_item.status, o_out_item.read_data);
                    end
                end
            end
        end
    end

    function automatic vcde_pkg::t_in_item make_cmd(vcde_pkg::t_action a, vcde_pkg::t_mode md,
                                                    int xa, int ya, int za,
                                                    int xb, int yb, int zb, int bi);
        vcde_pkg::t_in_item c;
        c.action = a; c.mode = md;
        c.x_a = 4'(xa); c.y_a = 4'(ya); c.z_a = 4'(za);
        c.x_b = 4'(xb); c.y_b = 4'(yb); c.z_b = 4'(zb);
        c.byte_index = 4'(bi);
        return c;
    endfunction

    // Random command: mostly legal coordinates with small boxes, some noise.
    function automatic vcde_pkg::t_in_item random_cmd();
        vcde_pkg::t_in_item c;
        int t;
        c = IN_W'({$urandom, $urandom});
        if ($urandom_range(9) < 8) begin
            c.mode = ($urandom_range(19) == 0) ? vcde_pkg::MODE_BAD : 2'($urandom_range(2));
            c.x_a = 4'($urandom_range(9));
            c.y_a = 4'($urandom_range(9));
            c.z_a = 4'($urandom_range(9));
            if (c.action inside {vcde_pkg::ACT_FILL, vcde_pkg::ACT_HOLLOW, vcde_pkg::ACT_EDGES}
                && $urandom_range(9) < 9) begin
                // ordered corners, usually small
                t = ($urandom_range(7) == 0) ? 9 : 3;
                c.x_b = 4'((c.x_a + $urandom_range(t) > 9) ? 9 : c.x_a + $urandom_range(t));
                c.y_b = 4'((c.y_a + $urandom_range(t) > 9) ? 9 : c.y_a + $urandom_range(t));
                c.z_b = 4'((c.z_a + $urandom_range(t) > 9) ? 9 : c.z_a + $urandom_range(t));
            end else if ($urandom_range(4) != 0) begin
                c.x_b = 4'($urandom_range(9));
                c.y_b = 4'($urandom_range(9));
                c.z_b = 4'($urandom_range(9));
            end
            if (c.action == vcde_pkg::ACT_READ && $urandom_range(4) != 0)
                c.byte_index = 4'($urandom_range(12));
        end
        // whole-cube ops are slow-ish and wipe the state; keep them rare
        if (c.action == vcde_pkg::ACT_WHOLE && $urandom_range(3) != 0)
            c.action = vcde_pkg::ACT_READ;
        return c;
    endfunction

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || i_in_valid || result_queue.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_out_ready    = 1'b0;
        i_in_item      = '0;
        for (int y = 0; y < EDGE; y++)
            for (int b = 0; b < NBYTES; b++)
                shadow_fb[y][b] = 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each action and mode, extremes and error cases
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_READ,   vcde_pkg::MODE_SET,
                                     0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_WHOLE,  vcde_pkg::MODE_SET,
                                     0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_READ,   vcde_pkg::MODE_BAD,
                                     0, 9, 0, 0, 0, 0, 12));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_WHOLE,  vcde_pkg::MODE_INVERT,
                                     0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_WHOLE,  vcde_pkg::MODE_BAD,
                                     0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_LAYER,  vcde_pkg::MODE_SET,
                                     0, 9, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_LAYER,  vcde_pkg::MODE_CLEAR,
                                     0, 15, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_VOXEL,  vcde_pkg::MODE_SET,
                                     9, 0, 9, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_VOXEL,  vcde_pkg::MODE_SET,
                                     10, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_VOXEL,  vcde_pkg::MODE_INVERT,
                                     0, 0, 15, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_FILL,   vcde_pkg::MODE_SET,
                                     0, 0, 0, 9, 9, 9, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_FILL,   vcde_pkg::MODE_CLEAR,
                                     5, 0, 0, 4, 9, 9, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_FILL,   vcde_pkg::MODE_CLEAR,
                                     0, 0, 3, 9, 9, 2, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_HOLLOW, vcde_pkg::MODE_INVERT,
                                     1, 1, 1, 8, 8, 8, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_HOLLOW, vcde_pkg::MODE_INVERT,
                                     2, 3, 4, 2, 3, 6, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_HOLLOW, vcde_pkg::MODE_BAD,
                                     0, 0, 0, 1, 1, 1, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_EDGES,  vcde_pkg::MODE_INVERT,
                                     0, 0, 0, 9, 9, 9, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_EDGES,  vcde_pkg::MODE_SET,
                                     3, 3, 3, 3, 3, 3, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_LINE,   vcde_pkg::MODE_INVERT,
                                     0, 0, 0, 9, 9, 9, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_LINE,   vcde_pkg::MODE_SET,
                                     9, 2, 0, 0, 7, 5, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_LINE,   vcde_pkg::MODE_SET,
                                     5, 5, 5, 15, 15, 15, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_LINE,   vcde_pkg::MODE_CLEAR,
                                     15, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_READ,   vcde_pkg::MODE_SET,
                                     0, 10, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_READ,   vcde_pkg::MODE_SET,
                                     0, 0, 0, 0, 0, 0, 13));
        cmd_queue.push_back(make_cmd(vcde_pkg::ACT_READ,   vcde_pkg::MODE_SET,
                                     0, 0, 0, 0, 0, 0, 15));

        // random phases: none, sender idle, receiver stall, both light
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            send_idle_pct  = (ph == 1) ? 85 : (ph == 3) ? 10 : 0;
            recv_stall_pct = (ph == 2) ? 85 : (ph == 3) ? 10 : 0;
            for (int i = 0; i < 150; i++) cmd_queue.push_back(random_cmd());
        end
        wait_drained();
        repeat (2500) @(posedge i_clk);
        if (mismatch_count == 0 && result_queue.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
